// ===== src/clnw_pkg.sv =====
`default_nettype none

package clnw_pkg;

    localparam int unsigned QDEPTH = 2;
    localparam int unsigned QPW    = $clog2(QDEPTH);

    localparam logic [2:0] REQ_PRINT  = 3'd0;
    localparam logic [2:0] REQ_RAW    = 3'd1;
    localparam logic [2:0] REQ_SETCUR = 3'd2;
    localparam logic [2:0] REQ_CLEAR  = 3'd3;
    localparam logic [2:0] REQ_GOTO   = 3'd4;

    localparam logic [7:0] CURSOR_HOME = 8'h80;
    localparam logic [7:0] CMD_CLEAR   = 8'h01;

    localparam int unsigned PAW = 3;
    localparam logic [PAW-1:0] ADDR_DISPLAY_MODE = 3'd0;

    typedef struct packed {
        logic [7:0] byte0;
        logic       rs0;
        logic [7:0] byte1;
        logic       rs1;
        logic       four;
        logic [7:0] cursor;
    } t_job;

    function automatic logic [7:0] wrap_cursor(input logic mode, input logic [7:0] a);
        logic [7:0] r;
        r = a;
        if (mode) begin
            unique case (a)
                8'h94:   r = 8'hC0;
                8'hD4:   r = 8'h94;
                8'hA8:   r = 8'hD4;
                8'hE8:   r = 8'h80;
                default: r = a;
            endcase
        end else begin
            unique case (a)
                8'h90:   r = 8'hC0;
                8'hD0:   r = 8'h80;
                default: r = a;
            endcase
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/clnw_front.sv =====
`default_nettype none

module clnw_front import clnw_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_display_mode,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [2:0] i_req_type,
    input  wire logic [7:0] i_value,
    input  wire logic       i_q_full,
    output logic            o_push,
    output t_job            o_job
);

    logic [7:0] r_cursor;
    logic [7:0] n_cursor;
    logic [7:0] wrapped;
    logic       emits;
    logic       accept;

    assign o_stall = i_q_full;
    assign accept  = i_valid & ~i_q_full;
    assign wrapped = wrap_cursor(i_display_mode, r_cursor);

    always_comb begin
        n_cursor    = r_cursor;
        emits       = 1'b0;
        o_job       = '0;
        o_job.byte0 = i_value;
        unique case (i_req_type)
            REQ_PRINT: begin
                o_job.byte0 = wrapped;
                o_job.byte1 = i_value;
                o_job.rs1   = 1'b1;
                o_job.four  = 1'b1;
                n_cursor    = wrapped + 8'd1;
                emits       = 1'b1;
            end
            REQ_RAW: begin
                emits = 1'b1;
            end
            REQ_SETCUR: begin
                n_cursor = i_value;
            end
            REQ_CLEAR: begin
                o_job.byte0 = CMD_CLEAR;
                n_cursor    = CURSOR_HOME;
                emits       = 1'b1;
            end
            REQ_GOTO: begin
                n_cursor = i_value;
                emits    = 1'b1;
            end
            default: begin
                emits = 1'b0;
            end
        endcase
        o_job.cursor = n_cursor;
    end

    assign o_push = accept & emits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor <= CURSOR_HOME;
        end else if (accept) begin
            r_cursor <= n_cursor;
        end
    end

endmodule

`default_nettype wire

// ===== src/clnw_fifo.sv =====
`default_nettype none

module clnw_fifo import clnw_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_data,
    output logic      o_full,
    input  wire logic i_pop,
    output t_job      o_data,
    output logic      o_empty
);

    t_job           r_mem [QDEPTH];
    logic [QPW-1:0] r_wr_ptr;
    logic [QPW-1:0] r_rd_ptr;
    logic [QPW:0]   r_count;

    assign o_full  = (r_count == (QPW+1)'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (QPW+1)'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - (QPW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== src/clnw_back.sv =====
`default_nettype none

module clnw_back import clnw_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_job i_q_data,
    input  wire logic i_q_empty,
    output logic      o_pop,
    output logic       o_valid,
    input  wire logic  i_stall,
    output logic [3:0] o_nibble,
    output logic       o_reg_select,
    output logic       o_last,
    output logic [7:0] o_cursor_after
);

    logic       r_busy;
    logic [1:0] r_idx;
    t_job       r_job;
    logic [7:0] cur_byte;
    logic       done;
    logic       load;

    assign cur_byte       = r_idx[1] ? r_job.byte1 : r_job.byte0;
    assign o_nibble       = r_idx[0] ? cur_byte[3:0] : cur_byte[7:4];
    assign o_reg_select   = r_idx[1] ? r_job.rs1 : r_job.rs0;
    assign o_last         = r_job.four ? (r_idx == 2'd3) : (r_idx == 2'd1);
    assign o_cursor_after = r_job.cursor;
    assign o_valid        = r_busy;

    assign done  = r_busy & ~i_stall & o_last;
    assign load  = ~i_q_empty & (~r_busy | done);
    assign o_pop = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (load) begin
            r_busy <= 1'b1;
            r_idx  <= 2'd0;
        end else if (done) begin
            r_busy <= 1'b0;
        end else if (r_busy && !i_stall) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_job <= i_q_data;
        end
    end

    a_two_nibble_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !r_job.four) |-> !r_idx[1])
        else $error("two-nibble request ran past its second nibble");

    a_drain_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (done && i_q_empty) |=> !o_valid)
        else $error("output stayed valid after the last nibble with an empty queue");

    a_load_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> (o_valid && r_idx == 2'd0))
        else $error("a loaded request did not start at its first nibble");

endmodule

`default_nettype wire

// ===== src/char_lcd_nibble_writer_top.sv =====
// With the back end idle, an accepted request is first registered in the queue and
// then loaded into the back end's job register, after which its first nibble is valid.
// The back end sends one nibble per cycle while i_stall is low: a print request sends
// four nibbles, a raw command, clear or go-to two, and a silent cursor set none.
// The two-entry queue lets the front keep accepting requests while nibbles stall, until it fills.
// Reset is synchronous and active low: the cursor returns to 0x80, the mode to
// 16x2 wrapping, and the queue and the output empty.
`default_nettype none

module char_lcd_nibble_writer_top import clnw_pkg::*; (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [PAW-1:0] paddr,
    input  wire logic [31:0]    pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  wire logic           i_valid,
    output logic                o_stall,
    input  wire logic [2:0]     i_req_type,
    input  wire logic [7:0]     i_value,
    output logic                o_valid,
    input  wire logic           i_stall,
    output logic [3:0]          o_nibble,
    output logic                o_reg_select,
    output logic                o_last,
    output logic [7:0]          o_cursor_after
);

    logic r_display_mode;
    logic q_full;
    logic q_empty;
    logic push;
    logic pop;
    t_job job_in;
    t_job job_out;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_DISPLAY_MODE) ? {31'd0, r_display_mode} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_display_mode <= 1'b0;
        end else if (psel && penable && pwrite && paddr == ADDR_DISPLAY_MODE) begin
            r_display_mode <= pwdata[0];
        end
    end

    clnw_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_display_mode (r_display_mode),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_req_type     (i_req_type),
        .i_value        (i_value),
        .i_q_full       (q_full),
        .o_push         (push),
        .o_job          (job_in)
    );

    clnw_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (job_in),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_data  (job_out),
        .o_empty (q_empty)
    );

    clnw_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_data       (job_out),
        .i_q_empty      (q_empty),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_nibble       (o_nibble),
        .o_reg_select   (o_reg_select),
        .o_last         (o_last),
        .o_cursor_after (o_cursor_after)
    );

endmodule

`default_nettype wire
